// ----- design/triangle_lattice_node_index_assert.svh -----
// Assertion macros for the triangle lattice node index block.
`ifndef TRIANGLE_LATTICE_NODE_INDEX_ASSERT_SVH
`define TRIANGLE_LATTICE_NODE_INDEX_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define TLNI_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion lbl failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define TLNI_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion lbl failed");

`endif

// ----- design/tlni_pkg.sv -----
// Shared widths, constants and controller/datapath interface types.
package tlni_pkg;

	localparam int unsigned DEG_W          = 5;
	localparam int unsigned COORD_W        = 5;
	localparam int unsigned NODE_W         = 10;
	localparam int unsigned MAX_DEGREE_DEF = 31;
	localparam logic [DEG_W-1:0] DEGREE_RESET = 5'd3;

	typedef struct packed {
		logic load;
		logic eval;
		logic step;
	} cmd_t;

	typedef struct packed {
		logic top_hit;
		logic ring_hit;
	} status_t;

endpackage

// ----- design/tlni_ctrl.sv -----
// Controller state machine for the node index search.
module tlni_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  tlni_pkg::status_t status,
	output tlni_pkg::cmd_t    cmd,
	output logic              busy,
	output logic              done
);
	import tlni_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EVAL = 4'b0010,
		ST_RING = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_EVAL;
			end
			ST_EVAL: begin
				state_d = status.top_hit ? ST_DONE : ST_RING;
			end
			ST_RING: begin
				if (status.ring_hit) state_d = ST_DONE;
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign cmd.load = start && (state_q == ST_IDLE);
	assign cmd.eval = (state_q == ST_EVAL);
	assign cmd.step = (state_q == ST_RING);
	assign busy     = (state_q != ST_IDLE);
	assign done     = (state_q == ST_DONE);

endmodule

// ----- design/tlni_datapath.sv -----
// Datapath: degree register, boundary tests and ring-by-ring interior search.
module tlni_datapath #(
	parameter int unsigned MAX_DEGREE = tlni_pkg::MAX_DEGREE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          poly_degree_we,
	input  logic [tlni_pkg::DEG_W-1:0]    poly_degree,
	input  logic [tlni_pkg::COORD_W-1:0]  row_i,
	input  logic [tlni_pkg::COORD_W-1:0]  col_j,
	input  tlni_pkg::cmd_t                cmd,
	output tlni_pkg::status_t             status,
	output logic [tlni_pkg::NODE_W-1:0]   node_index,
	output logic                          out_of_range
);
	import tlni_pkg::*;

	localparam logic [DEG_W:0] MAX_DEG_W = (DEG_W + 1)'(MAX_DEGREE);

	logic [DEG_W-1:0]   degree_q;
	logic [COORD_W-1:0] i_q;
	logic [COORD_W-1:0] j_q;
	logic [DEG_W-1:0]   d_q;
	logic [COORD_W-1:0] ri_q;
	logic [COORD_W-1:0] rj_q;
	logic [DEG_W-1:0]   vd_q;
	logic [NODE_W-1:0]  chk_q;
	logic [NODE_W-1:0]  node_q;
	logic               oor_q;

	logic [DEG_W-1:0]   deg_sat;
	logic [COORD_W:0]   sum_ij;
	logic               oor;
	logic [NODE_W-1:0]  i10;
	logic [NODE_W-1:0]  j10;
	logic [NODE_W-1:0]  d10;
	logic               top_hit;
	logic [NODE_W-1:0]  top_node;

	logic               ring_fail;
	logic [COORD_W-1:0] ni;
	logic [COORD_W-1:0] nj;
	logic [DEG_W-1:0]   nv;
	logic [NODE_W-1:0]  ni10;
	logic [NODE_W-1:0]  nj10;
	logic [NODE_W-1:0]  nv10;
	logic               ring_hit;
	logic [NODE_W-1:0]  ring_node;
	logic [NODE_W-1:0]  chk_next;

	assign deg_sat = ({1'b0, degree_q} > MAX_DEG_W) ? MAX_DEG_W[DEG_W-1:0] : degree_q;

	// boundary tests
	assign sum_ij = {1'b0, i_q} + {1'b0, j_q};
	assign oor    = sum_ij > {1'b0, d_q};
	assign i10    = NODE_W'(i_q);
	assign j10    = NODE_W'(j_q);
	assign d10    = NODE_W'(d_q);

	always_comb begin
		top_hit  = 1'b1;
		top_node = '0;
		priority if (oor) begin
			top_node = '0;
		end else if (i_q == '0 && j_q == '0) begin
			top_node = '0;
		end else if (j_q == d_q) begin
			top_node = NODE_W'(1);
		end else if (i_q == d_q) begin
			top_node = NODE_W'(2);
		end else if (sum_ij == {1'b0, d_q}) begin
			top_node = d10 + i10 + NODE_W'(1);
		end else if (j_q == '0) begin
			top_node = NODE_W'(3) * d10 - i10;
		end else if (i_q == '0) begin
			top_node = j10 + NODE_W'(2);
		end else begin
			top_hit  = 1'b0;
			top_node = '0;
		end
	end

	// one ring per step
	assign ring_fail = (vd_q < DEG_W'(3)) || (ri_q == '0) || (rj_q == '0);
	assign ni        = ri_q - COORD_W'(1);
	assign nj        = rj_q - COORD_W'(1);
	assign nv        = vd_q - DEG_W'(3);
	assign ni10      = NODE_W'(ni);
	assign nj10      = NODE_W'(nj);
	assign nv10      = NODE_W'(nv);
	assign chk_next  = chk_q + NODE_W'(3) * nv10;

	always_comb begin
		ring_hit  = 1'b1;
		ring_node = '0;
		priority if (ring_fail) begin
			ring_node = '0;
		end else if (ni == '0 && nj == '0) begin
			ring_node = chk_q + NODE_W'(1);
		end else if (ni == '0 && DEG_W'(nj) == nv) begin
			ring_node = chk_q + NODE_W'(2);
		end else if (DEG_W'(ni) == nv && nj == '0) begin
			ring_node = chk_q + NODE_W'(3);
		end else if (ni == '0) begin
			ring_node = chk_q + nj10 + NODE_W'(3);
		end else if (nj == '0) begin
			ring_node = chk_q + (nv10 - ni10) + NODE_W'(2) * nv10 + NODE_W'(1);
		end else if (ni10 + nj10 == nv10) begin
			ring_node = chk_q + nv10 + ni10 + NODE_W'(2);
		end else begin
			ring_hit  = 1'b0;
			ring_node = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q <= DEGREE_RESET;
		end else if (poly_degree_we) begin
			degree_q <= poly_degree;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			i_q <= row_i;
			j_q <= col_j;
			d_q <= deg_sat;
		end
		if (cmd.eval) begin
			node_q <= top_node;
			oor_q  <= oor;
			ri_q   <= i_q;
			rj_q   <= j_q;
			vd_q   <= d_q;
			chk_q  <= NODE_W'(3) * d10 - NODE_W'(1);
		end
		if (cmd.step) begin
			if (ring_hit) begin
				node_q <= ring_node;
				oor_q  <= 1'b0;
			end else begin
				ri_q  <= ni;
				rj_q  <= nj;
				vd_q  <= nv;
				chk_q <= chk_next;
			end
		end
	end

	assign status.top_hit  = top_hit;
	assign status.ring_hit = ring_hit;
	assign node_index      = node_q;
	assign out_of_range    = oor_q;

endmodule

// ----- design/triangle_lattice_node_index.sv -----
// Top level of the triangle lattice node index block.
//
// A point (row_i, col_j) is taken at a clock edge where start is high and busy is low.
// Corner, edge and out-of-range points go from the evaluate state straight to done; an interior
// point on ring r (r = 1 for the first ring inside the edges) goes to the ring search loop,
// which steps inward one ring at a time until it reaches ring r, then to done. node_index and
// out_of_range are valid only in the single cycle where done is high and must be taken
// then. busy stays high through the done cycle; the next point may start in the cycle
// after it. poly_degree is to be written only while busy is low; the block does not enforce it.
module triangle_lattice_node_index #(
	parameter int unsigned MAX_DEGREE = tlni_pkg::MAX_DEGREE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          poly_degree_we,
	input  logic [tlni_pkg::DEG_W-1:0]    poly_degree,
	input  logic                          start,
	output logic                          busy,
	input  logic [tlni_pkg::COORD_W-1:0]  row_i,
	input  logic [tlni_pkg::COORD_W-1:0]  col_j,
	output logic                          done,
	output logic [tlni_pkg::NODE_W-1:0]   node_index,
	output logic                          out_of_range
);
	import tlni_pkg::*;

	cmd_t    cmd;
	status_t status;

	tlni_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	tlni_datapath #(
		.MAX_DEGREE (MAX_DEGREE)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.poly_degree_we (poly_degree_we),
		.poly_degree    (poly_degree),
		.row_i          (row_i),
		.col_j          (col_j),
		.cmd            (cmd),
		.status         (status),
		.node_index     (node_index),
		.out_of_range   (out_of_range)
	);

endmodule

// ----- design/tlni_check.sv -----
// Port-level checker for the node index block, bound to the top level.
`include "triangle_lattice_node_index_assert.svh"

module tlni_check (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          done,
	input logic [tlni_pkg::NODE_W-1:0]   node_index,
	input logic                          out_of_range
);
	import tlni_pkg::*;

	`TLNI_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
	`TLNI_ASSERT_NEXT(a_accept_no_done, start && !busy, !done)
	`TLNI_ASSERT_SAME(a_done_busy, done, busy)
	`TLNI_ASSERT_NEXT(a_done_single, done, !done && !busy)
	`TLNI_ASSERT_SAME(a_oor_zero, done && out_of_range, node_index == '0)

endmodule

bind triangle_lattice_node_index tlni_check u_tlni_check (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.node_index   (node_index),
	.out_of_range (out_of_range)
);
